// ----- sv/tsdc_pkg.sv -----
// Package for the threshold sparsifier with error feedback and delta coding.
// Holds the field widths, register indexes and shared types.
// No dependencies.
package tsdc_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int POSITION_BITS = 31;
    localparam int CODE_BITS     = POSITION_BITS + 1;
    localparam int CFG_IDX_BITS  = 2;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic        [VALUE_BITS-2:0] t_pos_thresh;
    typedef logic        [POSITION_BITS-1:0] t_position;
    typedef logic        [CODE_BITS-1:0] t_code;
    typedef logic        [CFG_IDX_BITS-1:0] t_cfg_index;

    localparam t_cfg_index CFG_POSITIVE_THRESHOLD = 2'd0;
    localparam t_cfg_index CFG_NEGATIVE_THRESHOLD = 2'd1;
    localparam t_cfg_index CFG_DELTA_MODE         = 2'd2;

    // Clamp a value one bit wider than the format back into the signed range.
    function automatic t_value sat_narrow(input logic signed [VALUE_BITS:0] x);
        t_value res;
        if (x[VALUE_BITS] != x[VALUE_BITS-1]) begin
            res = x[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                : {1'b0, {(VALUE_BITS-1){1'b1}}};
        end else begin
            res = x[VALUE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ----- sv/threshold_sparsifier_delta_coder.sv -----
// The result passes through a sum stage and then a decision stage, both registered.
// Throughput: one element per cycle; the pipeline stalls only when the result is not taken.
// The saturating add is registered before the threshold compare and subtract.
// Reset (synchronous, active low) empties the pipeline, clears the last sent position
// and returns the thresholds and delta mode to their defaults.
module threshold_sparsifier_delta_coder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tsdc_pkg::t_value              i_gradient_value,
    input  tsdc_pkg::t_value              i_error_value,
    input  tsdc_pkg::t_position           i_element_position,
    input  logic                          i_first_of_set,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tsdc_pkg::t_value              o_new_error,
    output logic                          o_code_valid,
    output tsdc_pkg::t_code               o_code_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  tsdc_pkg::t_cfg_index          i_cfg_index,
    input  logic [tsdc_pkg::VALUE_BITS-1:0] i_cfg_data
);

    tsdc_pkg::t_pos_thresh r_pos_thresh;
    tsdc_pkg::t_value      r_neg_thresh;
    logic                  r_delta_mode;
    tsdc_pkg::t_position   r_last_pos;

    logic                  r_s1_valid;
    tsdc_pkg::t_value      r_s1_sum;
    tsdc_pkg::t_position   r_s1_pos;
    logic                  r_s1_first;

    logic                  r_out_valid;
    tsdc_pkg::t_value      r_new_error;
    logic                  r_code_valid;
    tsdc_pkg::t_code       r_code_word;

    logic                  adv_s2;
    logic                  adv_s1;

    tsdc_pkg::t_value      n_sum;
    logic                  hit_pos;
    logic                  hit_neg;
    logic                  send;
    tsdc_pkg::t_value      n_err;
    tsdc_pkg::t_position   base_pos;
    tsdc_pkg::t_position   coded_pos;
    tsdc_pkg::t_code       n_code;
    tsdc_pkg::t_position   n_last_pos;

    assign adv_s2      = !r_out_valid || i_out_ready;
    assign adv_s1      = !r_s1_valid || adv_s2;
    assign o_in_ready  = adv_s1;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid  = r_out_valid;
    assign o_new_error  = r_new_error;
    assign o_code_valid = r_code_valid;
    assign o_code_word  = r_code_word;

    // Stage 1: saturating sum of value and carried error.
    always_comb begin
        n_sum = tsdc_pkg::sat_narrow(
            {i_gradient_value[tsdc_pkg::VALUE_BITS-1], i_gradient_value} +
            {i_error_value[tsdc_pkg::VALUE_BITS-1], i_error_value});
    end

    // Stage 2: threshold decision, error update and position coding.
    always_comb begin
        hit_pos = $signed(r_s1_sum) >= $signed({1'b0, r_pos_thresh});
        hit_neg = $signed(r_s1_sum) <= $signed(r_neg_thresh);
        send    = hit_pos || hit_neg;
        if (hit_pos) begin
            n_err = tsdc_pkg::sat_narrow(
                {r_s1_sum[tsdc_pkg::VALUE_BITS-1], r_s1_sum} - {2'b00, r_pos_thresh});
        end else if (hit_neg) begin
            n_err = tsdc_pkg::sat_narrow(
                {r_s1_sum[tsdc_pkg::VALUE_BITS-1], r_s1_sum} -
                {r_neg_thresh[tsdc_pkg::VALUE_BITS-1], r_neg_thresh});
        end else begin
            n_err = r_s1_sum;
        end
        base_pos  = r_s1_first ? '0 : r_last_pos;
        coded_pos = r_delta_mode ? (r_s1_pos - base_pos) : r_s1_pos;
        n_code    = send ? {coded_pos, hit_pos} : '0;
        n_last_pos = send ? r_s1_pos : base_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_thresh <= '1;
            r_neg_thresh <= {1'b1, {(tsdc_pkg::VALUE_BITS-1){1'b0}}};
            r_delta_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tsdc_pkg::CFG_POSITIVE_THRESHOLD: begin
                    r_pos_thresh <= i_cfg_data[tsdc_pkg::VALUE_BITS-2:0];
                end
                tsdc_pkg::CFG_NEGATIVE_THRESHOLD: begin
                    r_neg_thresh <= i_cfg_data;
                end
                tsdc_pkg::CFG_DELTA_MODE: begin
                    r_delta_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_pos  <= '0;
        end else begin
            if (adv_s1) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv_s2) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_last_pos <= n_last_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s1 && i_in_valid) begin
            r_s1_sum   <= n_sum;
            r_s1_pos   <= i_element_position;
            r_s1_first <= i_first_of_set;
        end
        if (adv_s2 && r_s1_valid) begin
            r_new_error  <= n_err;
            r_code_valid <= send;
            r_code_word  <= n_code;
        end
    end

endmodule

// ----- sv/tsdc_checker.sv -----
// Port-level checks for threshold_sparsifier_delta_coder, attached with a bind.
// Depends on tsdc_pkg for field types.
module tsdc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input tsdc_pkg::t_value     o_new_error,
    input logic                 o_code_valid,
    input tsdc_pkg::t_code      o_code_word
);

    // A result that is not taken stays on the port.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_no_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_code_valid |-> o_code_word == '0)
        else $error("code word not zero without a code");

    // Crossing the positive threshold leaves a nonnegative error.
    a_pos_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_code_valid && o_code_word[0] |-> !o_new_error[tsdc_pkg::VALUE_BITS-1])
        else $error("negative error after positive code");

    // Crossing the negative threshold leaves an error at or below zero.
    a_neg_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_code_valid && !o_code_word[0] |->
        o_new_error[tsdc_pkg::VALUE_BITS-1] || o_new_error == '0)
        else $error("positive error after negative code");

endmodule

bind threshold_sparsifier_delta_coder tsdc_checker u_tsdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_new_error  (o_new_error),
    .o_code_valid (o_code_valid),
    .o_code_word  (o_code_word)
);
